FILE: sv/rpf_pkg.sv
// shared types and constants for the rectangle pattern fill pixel block
`default_nettype none

package rpf_pkg;

    // fill pattern codes
    typedef enum logic [2:0] {
        MODE_SOLID    = 3'd0,
        MODE_VERT     = 3'd1,
        MODE_HORIZ    = 3'd2,
        MODE_FWD_DIAG = 3'd3,
        MODE_BWD_DIAG = 3'd4,
        MODE_CHECKER  = 3'd5,
        MODE_POLKA    = 3'd6,
        MODE_NONE     = 3'd7
    } fill_mode_t;

    // register indexes on the configuration port
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_FILL_MODE      = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_COLORS = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_SIZE   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_POLKA_GAP      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_BORDER_SIZE    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_BORDER_COLOR   = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_RECT_WIDTH     = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_RECT_HEIGHT    = 3'd7;

    // byte address: 8 bytes per register
    localparam int ADDR_LSB  = 3;
    localparam int ADDR_BITS = ADDR_LSB + REG_IDX_BITS;
    localparam int DATA_BITS = 64;

    // configuration register set
    typedef struct packed {
        fill_mode_t   fill_mode;
        logic [63:0]  pattern_colors;
        logic [15:0]  pattern_size;
        logic [15:0]  polka_gap;
        logic [15:0]  border_size;
        logic [31:0]  border_color;
        logic [15:0]  rect_width;
        logic [15:0]  rect_height;
    } cfg_t;

    // per-pixel flags that travel alongside the dividers
    typedef struct packed {
        logic       outside;
        logic       border;
        logic       x_ge_half;
        fill_mode_t mode;
    } side_t;

endpackage

`default_nettype wire

FILE: sv/rpf_cfg.sv
// configuration register file behind the apb port
`default_nettype none

module rpf_cfg
    import rpf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t                    cfg_reg;
    logic [REG_IDX_BITS-1:0] idx;
    logic                    wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:ADDR_LSB];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_mode      <= MODE_SOLID;
            cfg_reg.pattern_colors <= '0;
            cfg_reg.pattern_size   <= 16'd1;
            cfg_reg.polka_gap      <= '0;
            cfg_reg.border_size    <= '0;
            cfg_reg.border_color   <= '0;
            cfg_reg.rect_width     <= 16'd1;
            cfg_reg.rect_height    <= 16'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FILL_MODE:      cfg_reg.fill_mode      <= fill_mode_t'(pwdata[2:0]);
                REG_PATTERN_COLORS: cfg_reg.pattern_colors <= pwdata;
                REG_PATTERN_SIZE:   cfg_reg.pattern_size   <= pwdata[15:0];
                REG_POLKA_GAP:      cfg_reg.polka_gap      <= pwdata[15:0];
                REG_BORDER_SIZE:    cfg_reg.border_size    <= pwdata[15:0];
                REG_BORDER_COLOR:   cfg_reg.border_color   <= pwdata[31:0];
                REG_RECT_WIDTH:     cfg_reg.rect_width     <= pwdata[15:0];
                REG_RECT_HEIGHT:    cfg_reg.rect_height    <= pwdata[15:0];
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_FILL_MODE:      prdata = {61'd0, cfg_reg.fill_mode};
            REG_PATTERN_COLORS: prdata = cfg_reg.pattern_colors;
            REG_PATTERN_SIZE:   prdata = {48'd0, cfg_reg.pattern_size};
            REG_POLKA_GAP:      prdata = {48'd0, cfg_reg.polka_gap};
            REG_BORDER_SIZE:    prdata = {48'd0, cfg_reg.border_size};
            REG_BORDER_COLOR:   prdata = {32'd0, cfg_reg.border_color};
            REG_RECT_WIDTH:     prdata = {48'd0, cfg_reg.rect_width};
            REG_RECT_HEIGHT:    prdata = {48'd0, cfg_reg.rect_height};
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/rect_pattern_fill_pixel.sv
// top level: pixel coordinate in, pattern or border color out
//
// One coordinate is taken on every clock cycle (busy stays low). Each one
// passes the entry stage, the divider stages and the result register, and
// done then rises with its color. The divider stages belong to two restoring
// dividers that run side by side, one quotient bit per register stage over
// max(COORD_BITS,16)+1 stages; they give the band parity and the polka
// remainders. Results cannot be held off, so the receiver must take
// done/pixel_color/outside_flag on the cycle they show. Registers sit at
// 8-byte steps on the apb port and must only be written while no pixel is
// in flight.
`default_nettype none

module rect_pattern_fill_pixel
    import rpf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic      [DATA_BITS-1:0]  prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    output logic                       done,
    output logic      [COLOR_BITS-1:0] pixel_color,
    output logic                       outside_flag
);

    // arithmetic width: coordinates or 16-bit registers plus one carry bit
    localparam int AW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
    localparam int NS = AW;

    cfg_t cfg;

    rpf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic          accept;
    logic [AW-1:0] x_w, y_w, w_w, h_w, b_w, s_w, g_w, half_w;
    logic [AW-1:0] dvd_a, dvd_b;
    logic          outside, border_hit;
    side_t         side_in;
    logic [AW-1:0] div_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // operands at the pipeline entry
    assign x_w    = AW'(pos_x);
    assign y_w    = AW'(pos_y);
    assign w_w    = AW'(COORD_BITS'(cfg.rect_width));
    assign h_w    = AW'(COORD_BITS'(cfg.rect_height));
    assign b_w    = AW'(cfg.border_size);
    assign g_w    = AW'(cfg.polka_gap);
    assign half_w = AW'(cfg.polka_gap[15:1]);
    assign s_w    = (cfg.pattern_size == 16'd0) ? AW'(1) : AW'(cfg.pattern_size);

    assign outside    = (x_w >= w_w) || (y_w >= h_w);
    assign border_hit = (b_w != '0) &&
                        ((y_w < b_w) || (y_w + b_w >= h_w) ||
                         (x_w < b_w) || (x_w + b_w >= w_w));

    // dividend selection per fill mode
    always_comb
    begin
        dvd_a = '0;
        dvd_b = '0;
        unique case (cfg.fill_mode)
            MODE_SOLID:    dvd_a = '0;
            MODE_VERT:     dvd_a = x_w;
            MODE_HORIZ:    dvd_a = y_w;
            MODE_FWD_DIAG: dvd_a = x_w + y_w;
            MODE_BWD_DIAG: dvd_a = x_w + (h_w - y_w);
            MODE_CHECKER:
            begin
                dvd_a = y_w;
                dvd_b = x_w;
            end
            MODE_POLKA:
            begin
                dvd_a = y_w + half_w;
                dvd_b = x_w - half_w;
            end
            MODE_NONE:     dvd_a = '0;
        endcase
    end

    assign side_in.outside   = outside;
    assign side_in.border    = border_hit;
    assign side_in.x_ge_half = (x_w >= half_w);
    assign side_in.mode      = cfg.fill_mode;

    // shared divisor; the user must keep it stable while pixels are in flight
    always_ff @(posedge clk)
    begin
        div_reg <= (cfg.fill_mode == MODE_POLKA) ? (s_w + g_w) : s_w;
    end

    // pipeline registers, index 0 is the entry stage
    logic          valid_reg [0:NS];
    logic [AW-1:0] dvd_a_reg [0:NS];
    logic [AW-1:0] dvd_b_reg [0:NS];
    logic [AW-1:0] rem_a_reg [0:NS];
    logic [AW-1:0] rem_b_reg [0:NS];
    logic          q_a_reg   [0:NS];
    logic          q_b_reg   [0:NS];
    side_t         side_reg  [0:NS];

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_a_reg[0] <= dvd_a;
        dvd_b_reg[0] <= dvd_b;
        rem_a_reg[0] <= '0;
        rem_b_reg[0] <= '0;
        q_a_reg[0]   <= 1'b0;
        q_b_reg[0]   <= 1'b0;
        side_reg[0]  <= side_in;
    end

    // restoring divider stages, one quotient bit each
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [AW:0]   trial_a, trial_b;
        logic          ge_a, ge_b;
        logic [AW-1:0] rem_a_next, rem_b_next;

        assign trial_a    = {rem_a_reg[k], dvd_a_reg[k][NS-1-k]};
        assign trial_b    = {rem_b_reg[k], dvd_b_reg[k][NS-1-k]};
        assign ge_a       = trial_a >= {1'b0, div_reg};
        assign ge_b       = trial_b >= {1'b0, div_reg};
        assign rem_a_next = ge_a ? AW'(trial_a - {1'b0, div_reg}) : trial_a[AW-1:0];
        assign rem_b_next = ge_b ? AW'(trial_b - {1'b0, div_reg}) : trial_b[AW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dvd_a_reg[k+1] <= dvd_a_reg[k];
            dvd_b_reg[k+1] <= dvd_b_reg[k];
            rem_a_reg[k+1] <= rem_a_next;
            rem_b_reg[k+1] <= rem_b_next;
            q_a_reg[k+1]   <= ge_a;
            q_b_reg[k+1]   <= ge_b;
            side_reg[k+1]  <= side_reg[k];
        end
    end

    // color selection from band parity and remainders
    logic [COLOR_BITS-1:0] c1, c2, fill_color, color_next;
    logic                  band_a, band_b, polka_dot;
    side_t                 side_out;

    assign c1       = cfg.pattern_colors[COLOR_BITS-1:0];
    assign c2       = cfg.pattern_colors[32 +: COLOR_BITS];
    assign band_a   = q_a_reg[NS];
    assign band_b   = q_b_reg[NS];
    assign side_out = side_reg[NS];
    assign polka_dot = (rem_a_reg[NS] > g_w) && side_out.x_ge_half &&
                       (rem_b_reg[NS] < s_w);

    always_comb
    begin
        fill_color = c1;
        unique case (side_out.mode)
            MODE_SOLID:    fill_color = c1;
            MODE_VERT:     fill_color = band_a ? c2 : c1;
            MODE_HORIZ:    fill_color = band_a ? c1 : c2;
            MODE_FWD_DIAG: fill_color = band_a ? c2 : c1;
            MODE_BWD_DIAG: fill_color = band_a ? c2 : c1;
            MODE_CHECKER:  fill_color = (band_a == band_b) ? c2 : c1;
            MODE_POLKA:    fill_color = polka_dot ? c2 : c1;
            MODE_NONE:     fill_color = '0;
        endcase
    end

    always_comb
    begin
        priority if (side_out.outside)
        begin
            color_next = '0;
        end
        else if (side_out.mode == MODE_NONE)
        begin
            color_next = '0;
        end
        else if (side_out.border)
        begin
            color_next = cfg.border_color[COLOR_BITS-1:0];
        end
        else
        begin
            color_next = fill_color;
        end
    end

    // result register
    logic                  done_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg   <= color_next;
        outside_reg <= side_out.outside;
    end

    assign done         = done_reg;
    assign pixel_color  = color_reg;
    assign outside_flag = outside_reg;

endmodule

`default_nettype wire

FILE: sv/rpf_checker.sv
// port-level checks for the rectangle pattern fill pixel block, with bind
`default_nettype none

module rpf_checker #(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [COLOR_BITS-1:0] pixel_color,
    input wire logic                  outside_flag
);

    localparam int LAT = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;

    // an outside pixel carries no color
    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!outside_flag || pixel_color == '0))
        else $error("outside pixel with nonzero color");

    // every accepted beat comes out after the fixed latency
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat did not produce a result");

    // no result without an accepted beat
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching beat");

endmodule

bind rect_pattern_fill_pixel rpf_checker #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
) u_rpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pixel_color  (pixel_color),
    .outside_flag (outside_flag)
);

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the rectangle pattern fill pixel block
`timescale 1ns / 1ps

module testbench;
    import rpf_pkg::*;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
    } coord_t;

    typedef struct {
        logic [31:0] color;
        logic        outside;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [15:0] pos_x = '0;
    logic [15:0] pos_y = '0;
    logic done;
    logic [31:0] pixel_color;
    logic outside_flag;

    // local copy of the register set
    fill_mode_t  m_mode = MODE_SOLID;
    logic [63:0] m_colors = '0;
    logic [15:0] m_size = 16'd1;
    logic [15:0] m_gap = '0;
    logic [15:0] m_bsize = '0;
    logic [31:0] m_bcolor = '0;
    logic [15:0] m_width = 16'd1;
    logic [15:0] m_height = 16'd1;

    coord_t pending_coords[$];
    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     gap_left = 0;
    bit     gaps_on = 1'b1;
    coord_t next_coord;
    pixel_t got_pixel;

    rect_pattern_fill_pixel dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .pos_x(pos_x), .pos_y(pos_y),
        .done(done), .pixel_color(pixel_color), .outside_flag(outside_flag)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

    function automatic logic band(logic [31:0] v, logic [31:0] s);
        return ((v / s) & 32'd1) != 0;
    endfunction

    // color of one pixel under the current register set
    function automatic pixel_t fill_color(logic [15:0] px, logic [15:0] py);
        pixel_t r;
        logic [31:0] x, y, w, h, s, g, b, c1, c2, off, period, half;
        x = px; y = py; w = m_width; h = m_height;
        s = (m_size == 0) ? 32'd1 : m_size;
        g = m_gap; b = m_bsize;
        c1 = m_colors[31:0]; c2 = m_colors[63:32];
        r.outside = 1'b0;
        r.color = '0;
        if (x >= w || y >= h)
        begin
            r.outside = 1'b1;
            return r;
        end
        case (m_mode)
            MODE_SOLID:    r.color = c1;
            MODE_VERT:     r.color = band(x, s) ? c2 : c1;
            MODE_HORIZ:    r.color = band(y, s) ? c1 : c2;
            MODE_FWD_DIAG: r.color = band(x + y, s) ? c2 : c1;
            MODE_BWD_DIAG: r.color = band(x + (h - y), s) ? c2 : c1;
            MODE_CHECKER:
            begin
                off = band(y, s) ? 32'd0 : s;
                r.color = band(x + off, s) ? c2 : c1;
            end
            MODE_POLKA:
            begin
                period = s + g;
                half = g / 2;
                r.color = c1;
                if (((y + half) % period) > g && x >= half && ((x - half) % period) < s)
                    r.color = c2;
            end
            default: return r;
        endcase
        if (b > 0 && (y < b || y + b >= h || x < b || x + b >= w))
            r.color = m_bcolor;
        return r;
    endfunction

    // driver: feeds queued coordinates with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_pixels.push_back(fill_color(pos_x, pos_y));
            if (start && busy)
            begin
                // hold the beat
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_coords.size() != 0)
            begin
                next_coord = pending_coords.pop_front();
                pos_x <= next_coord.x;
                pos_y <= next_coord.y;
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // monitor: compare every result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result color=%h outside=%b", pixel_color,
                             outside_flag);
            end
            else
            begin
                got_pixel = expected_pixels.pop_front();
                if (got_pixel.color !== pixel_color || got_pixel.outside !== outside_flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp color=%h outside=%b, got color=%h outside=%b",
                                 got_pixel.color, got_pixel.outside, pixel_color,
                                 outside_flag);
                end
            end
        end
    end

    task automatic reg_write(logic [REG_IDX_BITS-1:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {ADDR_LSB{1'b0}}};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FILL_MODE:      m_mode = fill_mode_t'(value[2:0]);
            REG_PATTERN_COLORS: m_colors = value;
            REG_PATTERN_SIZE:   m_size = value[15:0];
            REG_POLKA_GAP:      m_gap = value[15:0];
            REG_BORDER_SIZE:    m_bsize = value[15:0];
            REG_BORDER_COLOR:   m_bcolor = value[31:0];
            REG_RECT_WIDTH:     m_width = value[15:0];
            default:            m_height = value[15:0];
        endcase
    endtask

    task automatic configure(fill_mode_t mode, logic [63:0] colors, logic [15:0] size,
                             logic [15:0] gap, logic [15:0] bsize, logic [31:0] bcolor,
                             logic [15:0] w, logic [15:0] h);
        reg_write(REG_FILL_MODE, 64'(mode));
        reg_write(REG_PATTERN_COLORS, colors);
        reg_write(REG_PATTERN_SIZE, 64'(size));
        reg_write(REG_POLKA_GAP, 64'(gap));
        reg_write(REG_BORDER_SIZE, 64'(bsize));
        reg_write(REG_BORDER_COLOR, 64'(bcolor));
        reg_write(REG_RECT_WIDTH, 64'(w));
        reg_write(REG_RECT_HEIGHT, 64'(h));
    endtask

    task automatic add_coord(logic [15:0] x, logic [15:0] y);
        coord_t c;
        c.x = x;
        c.y = y;
        pending_coords.push_back(c);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_coords.size() != 0 || start || expected_pixels.size() != 0);
    endtask

    // mostly near the rectangle, sometimes anywhere
    function automatic logic [15:0] rand_coord(logic [15:0] lim);
        int top;
        top = (lim == 16'hFFFF) ? 65535 : lim + 1;
        if ($urandom_range(0, 9) < 8)
            return 16'($urandom_range(0, top));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_dim(int lo, int hi);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        if (r == 2)
            return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    initial
    begin
        logic [15:0] w, h, sz, gp, bs;
        fill_mode_t mode;
        logic [63:0] colors;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values
        add_coord(16'd0, 16'd0);
        add_coord(16'd1, 16'd0);
        add_coord(16'd0, 16'd1);
        add_coord(16'hFFFF, 16'hFFFF);
        wait_drained();

        // small solid rectangle with a one pixel border: corners, interior and just outside
        configure(MODE_SOLID, 64'hA5A5_5A5A_1234_5678, 16'd2, 16'd0, 16'd1,
                  32'hFFFF_FFFF, 16'd8, 16'd6);
        add_coord(16'd0, 16'd0);
        add_coord(16'd7, 16'd5);
        add_coord(16'd3, 16'd2);
        add_coord(16'd8, 16'd0);
        add_coord(16'd0, 16'd6);
        add_coord(16'd6, 16'd4);
        wait_drained();

        // unused mode keeps the border off but still flags outside
        reg_write(REG_FILL_MODE, 64'(MODE_NONE));
        add_coord(16'd0, 16'd0);
        add_coord(16'd3, 16'd3);
        add_coord(16'd9, 16'd1);
        wait_drained();

        // zero size and zero width
        configure(MODE_CHECKER, 64'hFFFF_FFFF_0000_0000, 16'd0, 16'd0, 16'd0,
                  32'd0, 16'd0, 16'd4);
        add_coord(16'd0, 16'd0);
        add_coord(16'd1, 16'd1);
        wait_drained();
        reg_write(REG_RECT_WIDTH, 64'd5);
        add_coord(16'd0, 16'd0);
        add_coord(16'd1, 16'd1);
        add_coord(16'd2, 16'd3);
        wait_drained();

        // random phases, the first few pinned to extremes
        for (int p = 0; p < 40; p++)
        begin
            mode = fill_mode_t'($urandom_range(0, 12) > 6 ? $urandom_range(0, 6) :
                                $urandom_range(0, 7));
            colors = {$urandom, $urandom};
            sz = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 12)) : rand_dim(0, 16);
            gp = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 9)) : rand_dim(0, 16);
            bs = ($urandom_range(0, 3) == 0) ? 16'd0 : rand_dim(1, 4);
            w = rand_dim(1, 48);
            h = rand_dim(1, 48);
            if (p == 0)
            begin
                mode = MODE_POLKA; sz = 16'hFFFF; gp = 16'hFFFF; bs = 16'd0;
                w = 16'hFFFF; h = 16'hFFFF; colors = '1;
            end
            else if (p == 1)
            begin
                mode = MODE_BWD_DIAG; sz = 16'd0; bs = 16'hFFFF;
                w = 16'hFFFF; h = 16'hFFFF;
            end
            else if (p == 2)
            begin
                mode = MODE_FWD_DIAG; sz = 16'd1; bs = 16'd0; w = 16'hFFFF; h = 16'hFFFF;
            end
            configure(mode, colors, sz, gp, bs, $urandom, w, h);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 55);
            for (int i = 0; i < n; i++)
                add_coord(rand_coord(w), rand_coord(h));
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
